@@ rtl/tclc_pkg.sv @@
// Package with shared types, constants and the power table entry function for the lux calculator.
package tclc_pkg;

    localparam int unsigned CountBits = 16;
    localparam int unsigned LuxBits   = 21;
    localparam int unsigned BandBits  = 3;
    localparam int unsigned CoefBits  = 24;
    localparam int unsigned RatioBits = 16;
    localparam logic [LuxBits-1:0] LuxMax = 21'h1FFFFF;

    typedef logic [BandBits-1:0] t_band;
    localparam t_band BAND_LOW    = 3'd0;
    localparam t_band BAND_MID    = 3'd1;
    localparam t_band BAND_HIGH   = 3'd2;
    localparam t_band BAND_TOP    = 3'd3;
    localparam t_band BAND_OVER   = 3'd4;
    localparam t_band BAND_DARK   = 3'd5;

    // Band coefficients in unsigned Q.24.
    localparam logic [CoefBits-1:0] K_B0_A = 24'd510027;
    localparam logic [CoefBits-1:0] K_B0_B = 24'd1040187;
    localparam logic [CoefBits-1:0] K_B1_A = 24'd375810;
    localparam logic [CoefBits-1:0] K_B1_B = 24'd520094;
    localparam logic [CoefBits-1:0] K_B2_A = 24'd214748;
    localparam logic [CoefBits-1:0] K_B2_B = 24'd256691;
    localparam logic [CoefBits-1:0] K_B3_A = 24'd24495;
    localparam logic [CoefBits-1:0] K_B3_B = 24'd18790;

    // Sideband that travels along the divider chain with each sample pair.
    typedef struct packed {
        logic                 vld;
        logic [CountBits-1:0] ch0;
        logic [CountBits-1:0] ch1;
        t_band                band;
    } t_tag;

    // Band choice by exact cross-multiplication.
    function automatic t_band pick_band(input logic [CountBits-1:0] ch0,
                                        input logic [CountBits-1:0] ch1);
        logic [22:0] a;
        logic [22:0] b;
        t_band       r;
        a = {7'd0, ch0};
        b = {7'd0, ch1};
        if (ch0 == '0)                r = BAND_DARK;
        else if ((b << 1) <= a)       r = BAND_LOW;
        else if (b * 23'd100 <= a * 23'd61) r = BAND_MID;
        else if (b * 23'd5 <= a * 23'd4)    r = BAND_HIGH;
        else if (b * 23'd10 <= a * 23'd13)  r = BAND_TOP;
        else                          r = BAND_OVER;
        return r;
    endfunction

    // floor(65536 * r^1.4) at interval midpoint r = (2i+1)/2^(bits+2);
    // binary search on y^5 * 2^lsh <= n^7 * 2^rsh, evaluated at elaboration.
    function automatic logic [RatioBits-1:0] pow_entry(input int unsigned idx,
                                                       input int unsigned bits);
        int          e;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic [255:0] lhs;
        logic [255:0] rhs;
        e  = 7 * (int'(bits) + 2) - 80;
        lo = 0;
        hi = 65535;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = 256'd1 << ((e > 0) ? e : 0);
            rhs = 256'd1 << ((e < 0) ? -e : 0);
            for (int k = 0; k < 5; k++) lhs = lhs * 256'(mid);
            for (int k = 0; k < 7; k++) rhs = rhs * 256'(2 * idx + 1);
            if (lhs <= rhs) lo = mid;
            else            hi = mid - 1;
        end
        return lo[RatioBits-1:0];
    endfunction

endpackage

@@ rtl/tclc_if.sv @@
// Valid/ready channel interface carrying a generic payload.
interface tclc_if #(
    parameter int unsigned W = 32
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tclc_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per cycle while the chain is enabled.
module tclc_div_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  tclc_pkg::t_tag             i_tag,
    input  logic [tclc_pkg::CountBits:0]   i_rem,
    input  logic [tclc_pkg::RatioBits-1:0] i_quo,
    output tclc_pkg::t_tag             o_tag,
    output logic [tclc_pkg::CountBits:0]   o_rem,
    output logic [tclc_pkg::RatioBits-1:0] o_quo
);
    import tclc_pkg::*;

    logic [CountBits+1:0] w_shift;
    logic [CountBits+1:0] w_diff;
    logic                 w_bit;

    // Shift in a zero numerator bit and try to subtract the divisor.
    assign w_shift = {i_rem, 1'b0};
    assign w_diff  = w_shift - {2'b00, i_tag.ch0};
    assign w_bit   = ~w_diff[CountBits+1];

    // Valid bit is control; remainder and quotient are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag.vld <= 1'b0;
        end else if (i_en) begin
            o_tag.vld <= i_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tag.ch0  <= i_tag.ch0;
            o_tag.ch1  <= i_tag.ch1;
            o_tag.band <= i_tag.band;
            o_rem      <= w_bit ? w_diff[CountBits:0] : w_shift[CountBits:0];
            o_quo      <= {i_quo[RatioBits-2:0], w_bit};
        end
    end
endmodule

@@ rtl/tclc_lux_calc.sv @@
// Lux arithmetic after the ratio: table lookup, products, difference and saturation.
module tclc_lux_calc #(
    parameter int unsigned POWER_TABLE_BITS  = 8,
    parameter int unsigned LUX_FRACTION_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  tclc_pkg::t_tag                 i_tag,
    input  logic [tclc_pkg::RatioBits-1:0] i_ratio,
    output logic                           o_vld,
    output logic [tclc_pkg::LuxBits-1:0]   o_lux,
    output tclc_pkg::t_band                o_band
);
    import tclc_pkg::*;

    localparam int unsigned TableSize = 1 << POWER_TABLE_BITS;
    localparam int unsigned IdxShift  = 15 - POWER_TABLE_BITS;
    localparam int unsigned IdxW      = RatioBits - IdxShift;

    // Constant power table.
    function automatic logic [TableSize*RatioBits-1:0] build_table();
        logic [TableSize*RatioBits-1:0] t;
        t = '0;
        for (int i = 0; i < TableSize; i++)
            t[i*RatioBits +: RatioBits] = pow_entry(i, POWER_TABLE_BITS);
        return t;
    endfunction
    localparam logic [TableSize*RatioBits-1:0] PowTable = build_table();

    // Stage 1: table lookup and coefficient selection.
    logic [IdxW-1:0]             w_idx_raw;
    logic [POWER_TABLE_BITS-1:0] w_idx;
    t_tag                        r_s1_tag;
    logic [RatioBits-1:0]        r_s1_pow;
    logic [CoefBits-1:0]         r_s1_ka;
    logic [CoefBits-1:0]         r_s1_kb;

    assign w_idx_raw = i_ratio[RatioBits-1:IdxShift];
    assign w_idx = (w_idx_raw > IdxW'(TableSize - 1)) ? POWER_TABLE_BITS'(TableSize - 1)
                                                       : w_idx_raw[POWER_TABLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_tag.vld <= 1'b0;
        else if (i_en) r_s1_tag.vld <= i_tag.vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_tag.ch0  <= i_tag.ch0;
            r_s1_tag.ch1  <= i_tag.ch1;
            r_s1_tag.band <= i_tag.band;
            r_s1_pow      <= PowTable[w_idx*RatioBits +: RatioBits];
            case (i_tag.band)
                BAND_MID:  begin r_s1_ka <= K_B1_A; r_s1_kb <= K_B1_B; end
                BAND_HIGH: begin r_s1_ka <= K_B2_A; r_s1_kb <= K_B2_B; end
                BAND_TOP:  begin r_s1_ka <= K_B3_A; r_s1_kb <= K_B3_B; end
                default:   begin r_s1_ka <= K_B0_A; r_s1_kb <= K_B0_B; end
            endcase
        end
    end

    // Stage 2: first products (low band: b*pow; linear bands: a*ch0, b*ch1).
    t_tag        r_s2_tag;
    logic [39:0] r_s2_p;
    logic [39:0] r_s2_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_tag.vld <= 1'b0;
        else if (i_en) r_s2_tag.vld <= r_s1_tag.vld;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_tag.ch0  <= r_s1_tag.ch0;
            r_s2_tag.ch1  <= r_s1_tag.ch1;
            r_s2_tag.band <= r_s1_tag.band;
            if (r_s1_tag.band == BAND_LOW) begin
                r_s2_p <= {r_s1_ka, 16'd0};
                r_s2_q <= 40'(r_s1_kb) * 40'(r_s1_pow);
            end else begin
                r_s2_p <= 40'(r_s1_ka) * 40'(r_s1_tag.ch0);
                r_s2_q <= 40'(r_s1_kb) * 40'(r_s1_tag.ch1);
            end
        end
    end

    // Stage 3: difference, clamped at zero.
    t_tag        r_s3_tag;
    logic [39:0] r_s3_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_tag.vld <= 1'b0;
        else if (i_en) r_s3_tag.vld <= r_s2_tag.vld;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_tag.ch0  <= r_s2_tag.ch0;
            r_s3_tag.ch1  <= r_s2_tag.ch1;
            r_s3_tag.band <= r_s2_tag.band;
            r_s3_d        <= (r_s2_q >= r_s2_p) ? 40'd0 : (r_s2_p - r_s2_q);
        end
    end

    // Stage 4: low band scales by ch0 in two 20-bit halves.
    t_tag        r_s4_tag;
    logic [55:0] r_s4_lo;
    logic [55:0] r_s4_hi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_tag.vld <= 1'b0;
        else if (i_en) r_s4_tag.vld <= r_s3_tag.vld;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_tag.ch0  <= r_s3_tag.ch0;
            r_s4_tag.ch1  <= r_s3_tag.ch1;
            r_s4_tag.band <= r_s3_tag.band;
            if (r_s3_tag.band == BAND_LOW) begin
                r_s4_lo <= 56'(r_s3_d[19:0]) * 56'(r_s3_tag.ch0);
                r_s4_hi <= 56'(r_s3_d[39:20]) * 56'(r_s3_tag.ch0);
            end else begin
                r_s4_lo <= 56'(r_s3_d);
                r_s4_hi <= 56'd0;
            end
        end
    end

    // Stage 5: combine, shift to the output fraction, saturate, and zero the dark and over bands.
    localparam int unsigned WideW = 80;
    logic [WideW-1:0] w_wide;
    logic [WideW-1:0] w_shr;
    assign w_wide = WideW'(r_s4_lo) + (WideW'(r_s4_hi) << 20);
    assign w_shr  = (r_s4_tag.band == BAND_LOW)
                  ? (w_wide >> (CoefBits + 16 - LUX_FRACTION_BITS))
                  : (w_wide >> (CoefBits - LUX_FRACTION_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else if (i_en) o_vld <= r_s4_tag.vld;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_band <= r_s4_tag.band;
            if (r_s4_tag.band == BAND_DARK || r_s4_tag.band == BAND_OVER)
                o_lux <= '0;
            else if (w_shr > WideW'(LuxMax))
                o_lux <= LuxMax;
            else
                o_lux <= w_shr[LuxBits-1:0];
        end
    end
endmodule

@@ rtl/two_channel_lux_calculator_top.sv @@
// Top level of the two-channel lux calculator: divider cell chain and lux pipeline.
// One sample pair is accepted every cycle while the output side takes transfers.
// The pipeline holds one entry stage, a chain of 16 division cells that each
// resolve one bit of the infrared/broadband ratio, and five arithmetic stages
// (table lookup, products, difference, scaling, saturation). The whole pipeline
// advances together and stalls only when the result stage is full and not taken;
// an item held there is not lost. Ready falls exactly while that stall lasts.
module two_channel_lux_calculator_top #(
    parameter int unsigned POWER_TABLE_BITS  = 8,
    parameter int unsigned LUX_FRACTION_BITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tclc_if.sink   i_in,
    tclc_if.source o_out
);
    import tclc_pkg::*;

    logic w_en;
    logic w_out_vld;
    logic [LuxBits-1:0] w_lux;
    t_band w_band;

    // The pipeline moves when the output stage is empty or being taken.
    assign w_en       = !w_out_vld || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = w_out_vld;
    assign o_out.data  = {w_lux, w_band};

    // Entry stage: register counts and decide the band.
    t_tag r_in_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_tag.vld <= 1'b0;
        else if (w_en) r_in_tag.vld <= i_in.valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_tag.ch1  <= i_in.data[CountBits-1:0];
            r_in_tag.ch0  <= i_in.data[2*CountBits-1:CountBits];
            r_in_tag.band <= pick_band(i_in.data[2*CountBits-1:CountBits],
                                       i_in.data[CountBits-1:0]);
        end
    end

    // Division cell chain: numerator ch1 << 16, remainder starts at ch1.
    t_tag                 w_tag [0:RatioBits];
    logic [CountBits:0]   w_rem [0:RatioBits];
    logic [RatioBits-1:0] w_quo [0:RatioBits];

    assign w_tag[0] = r_in_tag;
    assign w_rem[0] = {1'b0, r_in_tag.ch1};
    assign w_quo[0] = '0;

    for (genvar g = 0; g < RatioBits; g++) begin : g_div
        tclc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   (w_tag[g]),
            .i_rem   (w_rem[g]),
            .i_quo   (w_quo[g]),
            .o_tag   (w_tag[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    tclc_lux_calc #(
        .POWER_TABLE_BITS  (POWER_TABLE_BITS),
        .LUX_FRACTION_BITS (LUX_FRACTION_BITS)
    ) u_lux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag[RatioBits]),
        .i_ratio (w_quo[RatioBits]),
        .o_vld   (w_out_vld),
        .o_lux   (w_lux),
        .o_band  (w_band)
    );

    // Zero lux for the over and dark bands.
    a_zero_lux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_vld && (w_band == BAND_DARK || w_band == BAND_OVER)) |-> (w_lux == '0))
        else $error("nonzero lux for over or dark band");
    // Band code stays within its defined range.
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_vld |-> (w_band <= BAND_DARK))
        else $error("band code out of range");
    // A stalled result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_vld && !o_out.ready) |=> (w_out_vld && $stable(w_lux) && $stable(w_band)))
        else $error("stalled result changed");
endmodule

@@ test/tb_two_channel_lux_calculator_top.sv @@
// Self-checking testbench for the two-channel lux calculator top level.
module tb_two_channel_lux_calculator_top;
    import tclc_pkg::*;

    // Expected result of one sample pair.
    typedef struct {
        logic [LuxBits-1:0] lux;
        t_band              band;
    } t_lux_result;

    // Scoreboard: predicts lux and band for each accepted pair and checks results in order.
    class lux_scoreboard;
        t_lux_result    pending[$];
        logic [15:0]    pow_lut[256];
        int             errors;

        // Table of floor(65536 * r^1.4), with r the midpoint of each index interval.
        function void build_pow_lut();
            logic [255:0] lhs;
            logic [255:0] rhs;
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            errors = 0;
            for (int i = 0; i < 256; i++) begin
                lo = 0;
                hi = 65535;
                while (lo < hi) begin
                    mid = (lo + hi + 1) / 2;
                    // e = 7*10 - 80 = -10, so the shift lands on the right side.
                    lhs = 256'd1;
                    rhs = 256'd1 << 10;
                    for (int k = 0; k < 5; k++) lhs = lhs * 256'(mid);
                    for (int k = 0; k < 7; k++) rhs = rhs * 256'(2 * i + 1);
                    if (lhs <= rhs) lo = mid;
                    else            hi = mid - 1;
                end
                pow_lut[i] = lo[15:0];
            end
        endfunction

        function logic [LuxBits-1:0] saturate(logic [63:0] v);
            return (v > 64'(LuxMax)) ? LuxMax : v[LuxBits-1:0];
        endfunction

        function logic [LuxBits-1:0] linear_lux(logic [63:0] ch0, logic [63:0] ch1,
                                                logic [63:0] a, logic [63:0] b);
            logic [63:0] pos;
            logic [63:0] neg;
            pos = a * ch0;
            neg = b * ch1;
            if (neg >= pos) return '0;
            return saturate((pos - neg) >> 14);
        endfunction

        // Notes an accepted input transfer and queues its expected result.
        function void note_input(logic [15:0] ch0, logic [15:0] ch1);
            t_lux_result r;
            logic [63:0] c0;
            logic [63:0] c1;
            logic [63:0] ratio;
            logic [63:0] idx;
            logic [63:0] base;
            logic [63:0] sub;
            c0 = 64'(ch0);
            c1 = 64'(ch1);
            r.lux = '0;
            if (ch0 == 0) begin
                r.band = BAND_DARK;
            end else if (2 * c1 <= c0) begin
                r.band = BAND_LOW;
                ratio = (c1 << 16) / c0;
                idx = ratio >> 7;
                if (idx > 255) idx = 255;
                base = 64'(K_B0_A) << 16;
                sub = 64'(K_B0_B) * 64'(pow_lut[idx]);
                if (sub < base) r.lux = saturate((c0 * (base - sub)) >> 30);
            end else if (100 * c1 <= 61 * c0) begin
                r.band = BAND_MID;
                r.lux = linear_lux(c0, c1, 64'(K_B1_A), 64'(K_B1_B));
            end else if (5 * c1 <= 4 * c0) begin
                r.band = BAND_HIGH;
                r.lux = linear_lux(c0, c1, 64'(K_B2_A), 64'(K_B2_B));
            end else if (10 * c1 <= 13 * c0) begin
                r.band = BAND_TOP;
                r.lux = linear_lux(c0, c1, 64'(K_B3_A), 64'(K_B3_B));
            end else begin
                r.band = BAND_OVER;
            end
            pending.push_back(r);
        endfunction

        // Checks one output transfer against the oldest expectation.
        function void check_result(logic [LuxBits-1:0] lux, t_band band);
            t_lux_result r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result lux=%0d band=%0d", $time, lux, band);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (lux !== r.lux) begin
                $display("%0t: lux mismatch expected %0d actual %0d", $time, r.lux, lux);
                errors++;
            end
            if (band !== r.band) begin
                $display("%0t: band mismatch expected %0d actual %0d", $time, r.band, band);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int unsigned cycle_count = 0;
    bit stimulus_done;
    lux_scoreboard sb;

    tclc_if #(.W(32)) in_if  (.i_clk(i_clk));
    tclc_if #(.W(24)) out_if (.i_clk(i_clk));

    two_channel_lux_calculator_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Cycle counter used to place the idle-free window and the long output stall.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Input idling: about 24 percent of the time, none during the quiet window.
    function automatic bit sender_idles();
        if (cycle_count > 1500 && cycle_count < 2100) return 1'b0;
        return $urandom_range(0, 99) < 24;
    endfunction

    // Offers one sample pair and waits for its transfer.
    task automatic send_pair(logic [15:0] ch0, logic [15:0] ch1);
        while (sender_idles()) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= {ch0, ch1};
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Picks a count scaled from ch0 so that most pairs hit the interesting ratios.
    function automatic logic [15:0] scaled_ir(logic [15:0] ch0);
        logic [31:0] v;
        int unsigned num;
        int unsigned den;
        case ($urandom_range(0, 2))
            0: begin num = 1; den = 2; end
            1: begin num = 61; den = 100; end
            default: begin num = $urandom_range(0, 1) ? 4 : 13;
                           den = (num == 4) ? 5 : 10; end
        endcase
        v = (32'(ch0) * num) / den + $urandom_range(0, 2) - 1;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Stimulus: directed corners, then random pairs.
    initial begin
        logic [15:0] c0;
        logic [15:0] c1;
        logic [31:0] t;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_rst_n     <= 1'b0;
        stimulus_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Zero broadband, extremes, band boundaries, negative difference and saturation.
        send_pair(16'd0, 16'd0);
        send_pair(16'd0, 16'hFFFF);
        send_pair(16'hFFFF, 16'd0);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'd1, 16'd0);
        send_pair(16'd1, 16'd1);
        send_pair(16'd100, 16'd50);
        send_pair(16'd100, 16'd51);
        send_pair(16'd100, 16'd61);
        send_pair(16'd100, 16'd62);
        send_pair(16'd100, 16'd80);
        send_pair(16'd100, 16'd81);
        send_pair(16'd100, 16'd130);
        send_pair(16'd100, 16'd131);
        send_pair(16'hFFFF, 16'h7FFF);
        send_pair(16'hFFFF, 16'd39977);
        send_pair(16'hFFFF, 16'd52428);
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h5555, 16'h2AAA);
        send_pair(16'd40000, 16'd1);
        send_pair(16'd3, 16'd65535);
        for (int n = 0; n < 1200; n++) begin
            c0 = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 5))
                0: c1 = 16'($urandom_range(0, 65535));
                1: begin
                    t = (32'(c0) * $urandom_range(0, 1400)) / 1000;
                    c1 = (t > 65535) ? 16'hFFFF : t[15:0];
                end
                2, 3: c1 = scaled_ir(c0);
                4: begin
                    c0 = 16'($urandom_range(0, 300));
                    c1 = 16'($urandom_range(0, 400));
                end
                default: begin
                    c0 = 16'($urandom_range(50000, 65535));
                    c1 = 16'($urandom_range(0, c0 / 2));
                end
            endcase
            send_pair(c0, c1);
        end
        in_if.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Output side: random stalls, a quiet window, and one long hold-off.
    initial begin
        int unsigned hold;
        out_if.ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else if (cycle_count == 800) begin
                hold = 200;
                out_if.ready <= 1'b0;
            end else if (cycle_count > 1500 && cycle_count < 2100) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Monitors both channels at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.data[31:16], in_if.data[15:0]);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.data[23:3], t_band'(out_if.data[2:0]));
        end
    end

    initial begin
        sb = new();
        sb.build_pow_lut();
    end

    // End of run: drain, allow for the pipeline latency, then report.
    initial begin
        wait (stimulus_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("two_channel_lux_calculator_top regression: pass");
        end else begin
            $display("two_channel_lux_calculator_top regression: fail");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #(12 * 200000);
        $display("two_channel_lux_calculator_top regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tclc_pkg.sv
rtl/tclc_if.sv
rtl/tclc_div_cell.sv
rtl/tclc_lux_calc.sv
rtl/two_channel_lux_calculator_top.sv
test/tb_two_channel_lux_calculator_top.sv
